// ===== sv/wmtd_pkg.sv =====
// Package for the windowed median tone detector: widths, register indexes,
// reset values, cell command codes and the structs passed along the cell chain.
// No dependencies.
package wmtd_pkg;

  // Store depth, range 2 to 127.
  localparam int unsigned WINDOW_DEPTH = 64;
  localparam int unsigned IDX_W        = $clog2(WINDOW_DEPTH);
  localparam int unsigned CNT_W        = $clog2(WINDOW_DEPTH + 1);

  localparam int unsigned FREQ_W   = 19;
  localparam int unsigned LEVEL_W  = 24;
  localparam int unsigned STAMP_W  = 32;
  localparam int unsigned WLEN_W   = 16;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned SERIAL_W = 32;

  // Both windows use the wider value width; frequencies are zero-extended.
  localparam int unsigned VALUE_W = LEVEL_W;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  localparam int unsigned IN_USED_W  = FREQ_W + LEVEL_W + STAMP_W;
  localparam int unsigned IN_DATA_W  = ((IN_USED_W + 7) / 8) * 8;
  localparam int unsigned OUT_DET_BIT   = FREQ_W + LEVEL_W;
  localparam int unsigned OUT_COUNT_LSB = FREQ_W + LEVEL_W + 1;
  localparam int unsigned OUT_USED_W = FREQ_W + LEVEL_W + 1 + COUNT_W;
  localparam int unsigned OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;

  localparam logic [CFG_IDX_W-1:0] REG_BAND_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_THR = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_LEN   = 2'd3;

  localparam logic [FREQ_W-1:0]  BAND_LOW_RST  = 19'd2240;   // 140 Hz
  localparam logic [FREQ_W-1:0]  BAND_HIGH_RST = 19'd13120;  // 820 Hz
  localparam logic [LEVEL_W-1:0] LEVEL_THR_RST = 24'd23040;  // 90.0
  localparam logic [WLEN_W-1:0]  WIN_LEN_RST   = 16'd1000;

  // Command broadcast to every cell of a window.
  typedef enum logic [2:0] {
    OP_IDLE,
    OP_SEARCH,
    OP_DROP,
    OP_INSERT,
    OP_EVICT,
    OP_PACK
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic [VALUE_W-1:0]  value;
    logic [STAMP_W-1:0]  stamp;
    logic [SERIAL_W-1:0] serial;
    logic [WLEN_W-1:0]   limit;
  } cmd_t;

  typedef struct packed {
    logic                valid;
    logic [VALUE_W-1:0]  value;
    logic [STAMP_W-1:0]  stamp;
    logic [SERIAL_W-1:0] serial;
  } entry_t;

  // Running result of the earliest-arrival search, handed cell to cell.
  typedef struct packed {
    logic                found;
    logic [SERIAL_W-1:0] serial;
  } best_t;

  // Boundary entries: the left end looks occupied, the right end empty.
  localparam entry_t EDGE_LEFT  = '{valid: 1'b1, value: '0, stamp: '0, serial: '0};
  localparam entry_t EDGE_RIGHT = '{valid: 1'b0, value: '0, stamp: '0, serial: '0};
  localparam best_t  BEST_NONE  = '{found: 1'b0, serial: '0};

endpackage

// ===== sv/wmtd_cell.sv =====
// One cell of a sorted window: holds one entry and exchanges it with its neighbors.
// Depends on wmtd_pkg.
module wmtd_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  wmtd_pkg::cmd_t   cmd_i,
  input  wmtd_pkg::entry_t left_i,
  input  logic            left_keep_i,
  input  wmtd_pkg::entry_t right_i,
  input  wmtd_pkg::best_t  best_i,
  output wmtd_pkg::entry_t ent_o,
  output logic            keep_o,
  output wmtd_pkg::best_t  best_o
);
  import wmtd_pkg::*;

  logic                valid_q, valid_d;
  logic [VALUE_W-1:0]  value_q, value_d;
  logic [STAMP_W-1:0]  stamp_q, stamp_d;
  logic [SERIAL_W-1:0] serial_q, serial_d;
  best_t               best_q, best_d;

  logic [SERIAL_W-1:0] own_age;
  logic [SERIAL_W-1:0] in_age;
  logic [STAMP_W-1:0]  stamp_age;

  assign own_age   = cmd_i.serial - serial_q;
  assign in_age    = cmd_i.serial - best_i.serial;
  assign stamp_age = cmd_i.stamp - stamp_q;

  // An insert passes this cell by when the held value is not above the new one.
  assign keep_o = valid_q && (value_q <= cmd_i.value);

  always_comb begin
    valid_d  = valid_q;
    value_d  = value_q;
    stamp_d  = stamp_q;
    serial_d = serial_q;
    best_d   = best_q;
    case (cmd_i.op)
      OP_SEARCH: begin
        // Strict compare keeps the leftmost entry on a tie.
        if (valid_q && (!best_i.found || own_age > in_age)) begin
          best_d.found  = 1'b1;
          best_d.serial = serial_q;
        end else begin
          best_d = best_i;
        end
      end
      OP_DROP: begin
        if (valid_q && serial_q == cmd_i.serial) begin
          valid_d = 1'b0;
        end
      end
      OP_INSERT: begin
        if (!keep_o) begin
          if (left_keep_i) begin
            valid_d  = 1'b1;
            value_d  = cmd_i.value;
            stamp_d  = cmd_i.stamp;
            serial_d = cmd_i.serial;
          end else begin
            valid_d  = left_i.valid;
            value_d  = left_i.value;
            stamp_d  = left_i.stamp;
            serial_d = left_i.serial;
          end
        end
      end
      OP_EVICT: begin
        if (valid_q && stamp_age > STAMP_W'(cmd_i.limit)) begin
          valid_d = 1'b0;
        end
      end
      OP_PACK: begin
        // Holes travel right one cell per cycle while entries move left.
        if (!valid_q && right_i.valid) begin
          valid_d  = 1'b1;
          value_d  = right_i.value;
          stamp_d  = right_i.stamp;
          serial_d = right_i.serial;
        end else if (valid_q && !left_i.valid) begin
          valid_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      best_q  <= BEST_NONE;
    end else begin
      valid_q <= valid_d;
      best_q  <= best_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q  <= value_d;
    stamp_q  <= stamp_d;
    serial_q <= serial_d;
  end

  assign ent_o  = '{valid: valid_q, value: value_q, stamp: stamp_q, serial: serial_q};
  assign best_o = best_q;

endmodule

// ===== sv/wmtd_window.sv =====
// One sorted window: a chain of WINDOW_DEPTH cells plus its fill count and median read.
// Depends on wmtd_pkg and wmtd_cell.
module wmtd_window (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  wmtd_pkg::cmd_t              cmd_i,
  input  logic [wmtd_pkg::IDX_W-1:0]  med_idx_i,
  output logic                       packed_o,
  output logic [wmtd_pkg::CNT_W-1:0]  count_o,
  output logic [wmtd_pkg::VALUE_W-1:0] median_o,
  output wmtd_pkg::best_t             best_o
);
  import wmtd_pkg::*;

  entry_t                ent  [WINDOW_DEPTH];
  logic                  keep [WINDOW_DEPTH];
  best_t                 best [WINDOW_DEPTH];
  logic [WINDOW_DEPTH:0] vld;
  logic [WINDOW_DEPTH-1:0] holes;
  logic [WINDOW_DEPTH-1:0] last;

  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    entry_t left_ent;
    entry_t right_ent;
    logic   left_keep;
    best_t  best_in;

    if (i == 0) begin : g_first
      assign left_ent  = EDGE_LEFT;
      assign left_keep = 1'b1;
      assign best_in   = BEST_NONE;
    end else begin : g_inner
      assign left_ent  = ent[i-1];
      assign left_keep = keep[i-1];
      assign best_in   = best[i-1];
    end

    if (i == WINDOW_DEPTH - 1) begin : g_last
      assign right_ent = EDGE_RIGHT;
    end else begin : g_mid
      assign right_ent = ent[i+1];
    end

    wmtd_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd_i),
      .left_i     (left_ent),
      .left_keep_i(left_keep),
      .right_i    (right_ent),
      .best_i     (best_in),
      .ent_o      (ent[i]),
      .keep_o     (keep[i]),
      .best_o     (best[i])
    );

    assign vld[i] = ent[i].valid;
  end

  assign vld[WINDOW_DEPTH] = 1'b0;

  // Packed means the valid entries form an unbroken run from cell zero.
  assign holes    = ~vld[WINDOW_DEPTH-1:0] & vld[WINDOW_DEPTH:1];
  assign packed_o = ~|holes;
  assign last     = vld[WINDOW_DEPTH-1:0] & ~vld[WINDOW_DEPTH:1];

  always_comb begin
    count_o = '0;
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      if (last[i]) begin
        count_o = count_o | CNT_W'(i + 1);
      end
    end
  end

  assign median_o = ent[med_idx_i].value;
  assign best_o   = best[WINDOW_DEPTH-1];

endmodule

// ===== sv/windowed_median_tone_detector.sv =====
// Top level of the windowed median tone detector: sequencer, registers and stream ports.
// Depends on wmtd_pkg and wmtd_window.
//
// Usage: each input item on the s_axis channel is one spectral peak (frequency, magnitude
// and a millisecond arrival stamp). The block keeps two windows of up to WINDOW_DEPTH
// entries, one sorted by frequency and one by magnitude, inserts the peak into both, drops
// every entry older than window_length_ms and returns one result item on m_axis: the lower
// median of each window, the detect flag and the number of entries held.
// The block works on one item at a time and takes the next item only once it is idle
// again. Without a full store an item passes the insert, the eviction, the closing of the
// holes left by eviction, the count and the result step. A full store first runs a search
// wave over the chain, the drop and a second closing pass. The chain moves entries one
// cell per cycle.
// Reset empties both windows, clears the arrival counter and loads the register reset
// values; it takes effect at once, with no clearing pass. Configuration writes on the cfg
// port are taken in any cycle and must only be made while the block is idle.
// The result sits in an output register; a new item is accepted while it waits. If the
// receiver stalls, the next result waits in its final step until the register frees.
module windowed_median_tone_detector (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Input item. tdata from bit 0 up: peak_freq (19), peak_level (24), stamp_ms (32), zeros.
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [wmtd_pkg::IN_DATA_W-1:0]         s_axis_tdata,
  // Result item. tdata from bit 0 up: median_freq (19), median_level (24), detected (1),
  // window_count (7), zeros.
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [wmtd_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
  // Register write port.
  input  logic                                  cfg_we_i,
  input  logic [wmtd_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [wmtd_pkg::CFG_DATA_W-1:0]        cfg_data_i
);
  import wmtd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_DROP,
    S_PACK_DROP,
    S_INSERT,
    S_EVICT,
    S_PACK_EVICT,
    S_COUNT,
    S_RESULT
  } state_e;

  state_e              state_q;
  logic [IDX_W-1:0]    search_cnt_q;
  logic [SERIAL_W-1:0] serial_q;
  logic [CNT_W-1:0]    count_q;
  logic [IDX_W-1:0]    med_idx_q;

  // Item being worked on.
  logic [FREQ_W-1:0]  freq_q;
  logic [LEVEL_W-1:0] level_q;
  logic [STAMP_W-1:0] stamp_q;

  // Configuration registers.
  logic [FREQ_W-1:0]  band_low_q;
  logic [FREQ_W-1:0]  band_high_q;
  logic [LEVEL_W-1:0] level_thr_q;
  logic [WLEN_W-1:0]  win_len_q;

  // Output register.
  logic               out_valid_q;
  logic [FREQ_W-1:0]  out_freq_q;
  logic [LEVEL_W-1:0] out_level_q;
  logic               out_det_q;
  logic [COUNT_W-1:0] out_count_q;

  cmd_t               freq_cmd, level_cmd;
  op_e                op;
  logic [SERIAL_W-1:0] cmd_serial;
  logic               freq_packed, level_packed, packed_all;
  logic [CNT_W-1:0]   freq_count;
  logic [VALUE_W-1:0] freq_median, level_median;
  best_t              freq_best;
  logic [CNT_W-1:0]   count_m1;
  logic [FREQ_W-1:0]  med_freq;
  logic [LEVEL_W-1:0] med_level;
  logic               in_accept;
  logic               out_free;

  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign out_free      = !out_valid_q || m_axis_tready;
  assign packed_all    = freq_packed && level_packed;

  // Command that every cell of both windows carries out this cycle.
  always_comb begin
    case (state_q)
      S_SEARCH:     op = OP_SEARCH;
      S_DROP:       op = OP_DROP;
      S_PACK_DROP:  op = packed_all ? OP_IDLE : OP_PACK;
      S_INSERT:     op = OP_INSERT;
      S_EVICT:      op = OP_EVICT;
      S_PACK_EVICT: op = packed_all ? OP_IDLE : OP_PACK;
      default:      op = OP_IDLE;
    endcase
  end

  // The drop targets the serial that the search wave left at the end of the chain.
  // Both windows hold the same set of serials, so one search serves both.
  assign cmd_serial = (state_q == S_DROP) ? freq_best.serial : serial_q;

  assign freq_cmd = '{op: op, value: VALUE_W'(freq_q), stamp: stamp_q,
                      serial: cmd_serial, limit: win_len_q};
  assign level_cmd = '{op: op, value: VALUE_W'(level_q), stamp: stamp_q,
                       serial: cmd_serial, limit: win_len_q};

  wmtd_window u_freq_win (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (freq_cmd),
    .med_idx_i(med_idx_q),
    .packed_o (freq_packed),
    .count_o  (freq_count),
    .median_o (freq_median),
    .best_o   (freq_best)
  );

  wmtd_window u_level_win (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (level_cmd),
    .med_idx_i(med_idx_q),
    .packed_o (level_packed),
    .count_o  (),
    .median_o (level_median),
    .best_o   ()
  );

  // The lower median sits at position (count - 1) / 2; count is never zero here.
  assign count_m1  = freq_count - CNT_W'(1);
  assign med_freq  = FREQ_W'(freq_median);
  assign med_level = level_median;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_low_q  <= BAND_LOW_RST;
      band_high_q <= BAND_HIGH_RST;
      level_thr_q <= LEVEL_THR_RST;
      win_len_q   <= WIN_LEN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BAND_LOW:  band_low_q  <= cfg_data_i[FREQ_W-1:0];
        REG_BAND_HIGH: band_high_q <= cfg_data_i[FREQ_W-1:0];
        REG_LEVEL_THR: level_thr_q <= cfg_data_i[LEVEL_W-1:0];
        REG_WIN_LEN:   win_len_q   <= cfg_data_i[WLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      search_cnt_q <= '0;
      serial_q     <= '0;
      count_q      <= '0;
      med_idx_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      // The final step reloads the output register itself.
      if (m_axis_tready && state_q != S_RESULT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            freq_q       <= s_axis_tdata[FREQ_W-1:0];
            level_q      <= s_axis_tdata[FREQ_W +: LEVEL_W];
            stamp_q      <= s_axis_tdata[FREQ_W + LEVEL_W +: STAMP_W];
            search_cnt_q <= '0;
            // A full store first gives up its earliest arrival.
            state_q      <= (count_q == CNT_W'(WINDOW_DEPTH)) ? S_SEARCH : S_INSERT;
          end
        end
        S_SEARCH: begin
          // The wave travels cell by cell and must reach the end of the chain.
          search_cnt_q <= search_cnt_q + IDX_W'(1);
          if (search_cnt_q == IDX_W'(WINDOW_DEPTH - 1)) begin
            state_q <= S_DROP;
          end
        end
        S_DROP: begin
          state_q <= S_PACK_DROP;
        end
        S_PACK_DROP: begin
          if (packed_all) begin
            state_q <= S_INSERT;
          end
        end
        S_INSERT: begin
          serial_q <= serial_q + SERIAL_W'(1);
          state_q  <= S_EVICT;
        end
        S_EVICT: begin
          state_q <= S_PACK_EVICT;
        end
        S_PACK_EVICT: begin
          if (packed_all) begin
            state_q <= S_COUNT;
          end
        end
        S_COUNT: begin
          count_q   <= freq_count;
          med_idx_q <= IDX_W'(count_m1 >> 1);
          state_q   <= S_RESULT;
        end
        S_RESULT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_freq_q  <= med_freq;
            out_level_q <= med_level;
            out_det_q   <= (med_freq >= band_low_q) && (med_freq <= band_high_q) &&
                           (med_level > level_thr_q);
            out_count_q <= COUNT_W'(count_q);
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - OUT_USED_W){1'b0}},
                          out_count_q, out_det_q, out_level_q, out_freq_q};

endmodule

// ===== sv/wmtd_checker.sv =====
// Port-level checks for the windowed median tone detector, bound to the top level.
// Depends on wmtd_pkg.
module wmtd_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [wmtd_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
  import wmtd_pkg::*;

  // A stalled result holds its value until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result item changed or vanished while stalled");

  // The block works on one item at a time.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second item accepted while the first is in work");

  // A fresh result never appears right after an item was accepted.
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
    else $error("result item appeared one cycle after acceptance");

  // While a result is stalled the block cannot return to idle.
  a_busy_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready && !s_axis_tready |=> !s_axis_tready)
    else $error("block went idle while its result was still stalled");

endmodule

bind windowed_median_tone_detector wmtd_checker u_wmtd_checker (.*);
